@@ src/rgb2hsv_pkg.sv @@
// Shared types, constants and the divider step function for the RGB to HSV pipeline.
package rgb2hsv_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned PixW         = 4 * ChanW;
  localparam int unsigned HueTurn      = 256;
  localparam int unsigned HueSixth     = (HueTurn + 3) / 6;
  localparam int unsigned HueThird     = (HueTurn + 1) / 3;
  localparam int unsigned HueTwoThirds = HueTurn - HueThird;
  localparam int unsigned SatFull      = 255;
  localparam int unsigned DivStages    = 4;
  localparam int unsigned BitsPerStage = ChanW / DivStages;

  typedef logic [ChanW-1:0]   chan_t;
  typedef logic [2*ChanW-1:0] prod_t;

  // One restoring-divider lane: divisor, partial remainder, unused dividend
  // bits and the quotient bits produced so far.
  typedef struct packed {
    chan_t dvs;
    chan_t rem;
    chan_t low;
    chan_t quo;
  } div_lane_t;

  // One pixel in flight.
  typedef struct packed {
    chan_t     alpha;
    chan_t     value;
    chan_t     base;
    logic      neg;
    div_lane_t sat;
    div_lane_t hue;
  } pix_item_t;

  // Produce BitsPerStage quotient bits of one lane.
  function automatic div_lane_t div_step(input div_lane_t lane);
    div_lane_t        l;
    logic [ChanW:0]   trial;
    int               i;
    l = lane;
    for (i = 0; i < BitsPerStage; i++) begin
      trial = {l.rem, l.low[ChanW-1]};
      l.low = {l.low[ChanW-2:0], 1'b0};
      if (trial >= {1'b0, l.dvs}) begin
        l.rem = ChanW'(trial - {1'b0, l.dvs});
        l.quo = {l.quo[ChanW-2:0], 1'b1};
      end else begin
        l.rem = trial[ChanW-1:0];
        l.quo = {l.quo[ChanW-2:0], 1'b0};
      end
    end
    return l;
  endfunction

endpackage

@@ src/rgb2hsv_front.sv @@
// Front stage: channel extremes, hue sextant selection and divider setup.
module rgb2hsv_front
  import rgb2hsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [PixW-1:0] in_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output pix_item_t   out_item
);

  chan_t           r, g, b, hi, lo, chroma, mag, base;
  logic [ChanW:0]  diff;
  logic            grey;
  prod_t           hue_n, sat_n;
  pix_item_t       item_nxt;
  pix_item_t       item_r;
  logic            valid_r;

  // Find extremes and pick the sextant
  always_comb begin
    r = in_pixel[3*ChanW-1:2*ChanW];
    g = in_pixel[2*ChanW-1:ChanW];
    b = in_pixel[ChanW-1:0];
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    chroma = hi - lo;
    grey   = (hi == lo);
    if (r == hi) begin
      diff = {1'b0, g} - {1'b0, b};
      base = '0;
    end else if (g == hi) begin
      diff = {1'b0, b} - {1'b0, r};
      base = ChanW'(HueThird);
    end else begin
      diff = {1'b0, r} - {1'b0, g};
      base = ChanW'(HueTwoThirds);
    end
    mag   = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
    hue_n = prod_t'(mag) * prod_t'(HueSixth);
    sat_n = prod_t'(chroma) * prod_t'(SatFull);

    // Grey pixels divide zero by one
    item_nxt.alpha   = in_pixel[PixW-1:3*ChanW];
    item_nxt.value   = hi;
    item_nxt.base    = base;
    item_nxt.neg     = diff[ChanW];
    item_nxt.sat.dvs = grey ? ChanW'(1) : hi;
    item_nxt.sat.rem = sat_n[2*ChanW-1:ChanW];
    item_nxt.sat.low = sat_n[ChanW-1:0];
    item_nxt.sat.quo = '0;
    item_nxt.hue.dvs = grey ? ChanW'(1) : chroma;
    item_nxt.hue.rem = hue_n[2*ChanW-1:ChanW];
    item_nxt.hue.low = hue_n[ChanW-1:0];
    item_nxt.hue.quo = '0;
  end

  assign in_ready = !valid_r || out_ready;

  // Advance the stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ src/rgb2hsv_div_stage.sv @@
// Divider stage: two quotient bits of the saturation and hue lanes per beat.
module rgb2hsv_div_stage
  import rgb2hsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pix_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output pix_item_t out_item
);

  pix_item_t item_nxt;
  pix_item_t item_r;
  logic      valid_r;

  // Step both lanes
  always_comb begin
    item_nxt     = in_item;
    item_nxt.sat = div_step(in_item.sat);
    item_nxt.hue = div_step(in_item.hue);
  end

  assign in_ready = !valid_r || out_ready;

  // Advance the stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ src/rgb2hsv_back.sv @@
// Back stage: signed hue offset, wrap into the turn and output register.
module rgb2hsv_back
  import rgb2hsv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pix_item_t       in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PixW-1:0] out_pixel
);

  chan_t           offset, hue;
  logic [PixW-1:0] pixel_nxt;
  logic [PixW-1:0] pixel_r;
  logic            valid_r;

  // Apply sign, add base; the byte wrap adds the turn to negative hues
  always_comb begin
    offset    = in_item.neg ? ChanW'(-in_item.hue.quo) : in_item.hue.quo;
    hue       = in_item.base + offset;
    pixel_nxt = {in_item.alpha, hue, in_item.sat.quo, in_item.value};
  end

  assign in_ready = !valid_r || out_ready;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pixel = pixel_r;

endmodule

@@ src/rgb_to_hsv_converter_top.sv @@
// Top level of the streaming 8-bit RGB to HSV pixel converter.
// Converts one ARGB pixel to AHSV per beat and takes a new pixel every clock
// while the output side keeps up. The pipeline is one front stage for
// min/max and divider setup, four divider stages that each resolve two
// quotient bits of saturation and hue in parallel, and one output stage.
// Each stage has its own valid bit and a ready chain, so a stalled output
// register lets earlier stages keep filling their bubbles.
module rgb_to_hsv_converter_top
  import rgb2hsv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [PixW-1:0] in_tdata,   // pixel_argb[31:0]
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [PixW-1:0] out_tdata   // pixel_ahsv[31:0]
);

  pix_item_t stage_item  [DivStages+1];
  logic      stage_valid [DivStages+1];
  logic      stage_ready [DivStages+1];

  rgb2hsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_item  (stage_item[0])
  );

  // Divider chain
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    rgb2hsv_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_valid[s]),
      .in_ready  (stage_ready[s]),
      .in_item   (stage_item[s]),
      .out_valid (stage_valid[s+1]),
      .out_ready (stage_ready[s+1]),
      .out_item  (stage_item[s+1])
    );
  end

  rgb2hsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stage_valid[DivStages]),
    .in_ready  (stage_ready[DivStages]),
    .in_item   (stage_item[DivStages]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata)
  );

`ifndef SYNTHESIS
  // A free output side never blocks the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // Hue offset magnitude stays within one sextant
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid[DivStages] |-> stage_item[DivStages].hue.quo <= ChanW'(HueSixth))
    else $error("hue quotient beyond one sextant");

  // Final remainders are below their divisors
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid[DivStages] |->
      (stage_item[DivStages].hue.rem < stage_item[DivStages].hue.dvs) &&
      (stage_item[DivStages].sat.rem < stage_item[DivStages].sat.dvs))
    else $error("divider remainder not reduced");

  // A black pixel always has zero saturation
  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid[DivStages] && stage_item[DivStages].value == '0) |->
      stage_item[DivStages].sat.quo == '0)
    else $error("black pixel with nonzero saturation");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
